// ===== rtl/core/lzss_pkg.sv =====
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants for the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam logic [2:0] ST_RUN  = 3'd0;
  localparam logic [2:0] ST_OK   = 3'd1;
  localparam logic [2:0] ST_SIZE = 3'd2;
  localparam logic [2:0] ST_TYPE = 3'd3;
  localparam logic [2:0] ST_OVER = 3'd4;

  localparam logic [1:0] MODE_STORED = 2'd0;
  localparam logic [1:0] MODE_ELEM1  = 2'd1;
  localparam logic [1:0] MODE_ELEM2  = 2'd2;

  localparam logic [2:0] PH_FLAG  = 3'd0;
  localparam logic [2:0] PH_FRESH = 3'd1;
  localparam logic [2:0] PH_LOW   = 3'd2;
  localparam logic [2:0] PH_MID   = 3'd3;
  localparam logic [2:0] PH_LIT0  = 3'd4;

  localparam int unsigned OFFSET_BITS = 12;
  localparam logic [11:0] OFFSET_MASK = 12'hFFF;
  localparam logic [7:0]  FLAG_MSB    = 8'h80;

  // command from controller to datapath
  typedef struct packed {
    logic take;      // process accepted byte (decode step)
    logic copy_rd;   // issue a window read for the match copy
    logic copy_emit; // emit the byte just read
    logic finish;    // clear stream state after last item
  } lzss_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic       lit_emit;   // decode step emits the input byte
    logic       match_go;   // decode step starts a match copy
    logic [6:0] match_len;  // bytes to copy
  } lzss_stat_t;

endpackage

// ===== rtl/core/lzss_ram.sv =====
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/lzss_datapath.sv =====
// ----------------------------------------------------------------------------
// lzss_datapath
// Header and token decode, stream bookkeeping and the history window.
// ----------------------------------------------------------------------------
module lzss_datapath
  import lzss_pkg::*;
#(
  parameter int WINDOW_BYTES = 16384,
  parameter int LENGTH_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [LENGTH_BITS-1:0] out_length,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  input  lzss_cmd_t              cmd,
  output lzss_stat_t             stat,
  output logic [7:0]             emit_byte,
  output logic [2:0]             final_status
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam logic [13:0] WRITTEN_MAX = 14'h3FFF;

  logic [AW-1:0]          wr_pos;
  logic [AW-1:0]          rd_pos;
  logic [2:0]             header_count;
  logic [1:0]             mode_type;
  logic [7:0]             flag_bits;
  logic [3:0]             flags_left;
  logic [2:0]             token_phase;
  logic [7:0]             match_high_byte;
  logic [13:0]            written_count;
  logic [LENGTH_BITS-1:0] space_left;
  logic [2:0]             error_code;

  logic [2:0]  elem;
  logic [2:0]  minm;
  logic [15:0] info;
  logic [14:0] offset;
  logic [6:0]  length;
  logic        hdr;
  logic        active;
  logic        is_lit_phase;
  logic        is_cont;
  logic [2:0]  got_next;
  logic        tok_end;
  logic        emit_any;
  logic        ram_we;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;
  logic [2:0]  err_next;
  logic        byp;
  logic [7:0]  byp_data;
  logic [7:0]  copy_byte;

  always_comb begin
    case (mode_type)
      MODE_ELEM1: begin elem = 3'd1; minm = 3'd3; end
      MODE_ELEM2: begin elem = 3'd2; minm = 3'd2; end
      default:    begin elem = 3'd4; minm = 3'd1; end
    endcase
  end

  assign info   = {match_high_byte, in_byte};
  assign offset = {3'd0, info[OFFSET_BITS-1:0] & OFFSET_MASK} * {12'd0, elem};
  assign length = ({3'd0, info[15:12]} + {4'd0, minm}) * {4'd0, elem};
  assign hdr    = (header_count < 3'd4);
  assign active = !hdr && (error_code == ST_RUN);
  assign is_lit_phase = (token_phase == PH_FRESH) || (token_phase == PH_MID);
  assign is_cont      = (token_phase >= PH_LIT0);
  assign got_next     = token_phase - PH_LIT0 + 3'd1;

  always_comb begin
    stat.lit_emit  = 1'b0;
    stat.match_go  = 1'b0;
    stat.match_len = length;
    err_next       = error_code;
    tok_end        = 1'b0;
    if (active) begin
      if (mode_type == MODE_STORED) begin
        if (space_left == '0) begin
          err_next = ST_OVER;
        end else begin
          stat.lit_emit = 1'b1;
        end
      end else if (is_lit_phase) begin
        if (!flag_bits[7]) begin
          if (space_left < LENGTH_BITS'(elem)) begin
            err_next = ST_OVER;
          end else begin
            stat.lit_emit = 1'b1;
            tok_end = (elem == 3'd1);
          end
        end
      end else if (token_phase == PH_LOW) begin
        if (offset == '0 || offset > {1'b0, written_count} ||
            LENGTH_BITS'(length) > space_left) begin
          err_next = ST_OVER;
        end else begin
          stat.match_go = 1'b1;
        end
      end else if (is_cont) begin
        stat.lit_emit = 1'b1;
        tok_end = (got_next >= elem);
      end
    end
  end

  function automatic logic [LENGTH_BITS-1:0] space_left_after();
    space_left_after = stat.lit_emit ? space_left - 1'b1 : space_left;
  endfunction

  function automatic logic [2:0] phase_after();
    logic [2:0] p;
    p = token_phase;
    if (active && mode_type != MODE_STORED) begin
      if (token_phase == PH_FLAG) begin
        p = PH_FRESH;
      end else if (is_lit_phase) begin
        if (flag_bits[7]) p = PH_LOW;
        else if (stat.lit_emit) p = tok_end ? ((flags_left <= 4'd1) ? PH_FLAG : PH_MID) : 3'd5;
      end else if (is_cont) begin
        p = tok_end ? ((flags_left <= 4'd1) ? PH_FLAG : PH_MID) : token_phase + 3'd1;
      end
      // a match decision that succeeds ends the token at once; the controller then runs the copy
      else if (stat.match_go) p = (flags_left <= 4'd1) ? PH_FLAG : PH_MID;
    end
    phase_after = p;
  endfunction

  always_comb begin
    if (hdr && header_count != 3'd3) begin
      final_status = ST_OVER;
    end else if (err_next != ST_RUN) begin
      final_status = err_next;
    end else if (mode_type == MODE_STORED) begin
      final_status = (space_left_after() != '0) ? ST_SIZE : ST_OK;
    end else begin
      final_status = (phase_after() == PH_FLAG || phase_after() == PH_MID) ? ST_OK : ST_OVER;
    end
  end

  // offset one reads the byte written at the same edge
  assign copy_byte = byp ? byp_data : ram_rdata;

  assign emit_any  = (cmd.take && stat.lit_emit && mode_type != MODE_STORED) || cmd.copy_emit;
  assign ram_we    = emit_any;
  assign ram_wdata = cmd.copy_emit ? copy_byte : in_byte;
  assign emit_byte = cmd.copy_emit ? copy_byte : in_byte;
  assign rd_pos    = wr_pos - AW'(offset);

  logic [AW-1:0] copy_src;

  lzss_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_window (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_pos),
    .wdata(ram_wdata),
    .re   (cmd.copy_rd),
    .raddr(copy_src),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      copy_src <= '0;
    end else if (cmd.take && stat.match_go) begin
      copy_src <= rd_pos;
    end else if (cmd.copy_rd) begin
      copy_src <= copy_src + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp      <= 1'b0;
      byp_data <= '0;
    end else if (cmd.copy_rd) begin
      byp      <= ram_we && (wr_pos == copy_src);
      byp_data <= ram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      wr_pos          <= '0;
      header_count    <= '0;
      mode_type       <= MODE_STORED;
      flag_bits       <= '0;
      flags_left      <= '0;
      token_phase     <= PH_FLAG;
      match_high_byte <= '0;
      written_count   <= '0;
      space_left      <= '0;
      error_code      <= ST_RUN;
    end else begin
      if (emit_any) begin
        wr_pos <= wr_pos + 1'b1;
        if (written_count < WRITTEN_MAX) written_count <= written_count + 1'b1;
        if (space_left != '0) space_left <= space_left - 1'b1;
      end
      if (cmd.take) begin
        if (hdr) begin
          if (header_count == 3'd0) begin
            space_left <= out_length;
            mode_type  <= in_byte[1:0];
            if (in_byte > 8'd3) error_code <= ST_TYPE;
          end
          header_count <= header_count + 1'b1;
        end else if (active) begin
          error_code <= err_next;
          if (mode_type == MODE_STORED) begin
            if (stat.lit_emit) space_left <= space_left - 1'b1;
          end else if (token_phase == PH_FLAG) begin
            flag_bits   <= in_byte;
            flags_left  <= 4'd8;
            token_phase <= PH_FRESH;
          end else if (is_lit_phase && flag_bits[7]) begin
            match_high_byte <= in_byte;
            token_phase     <= PH_LOW;
          end else if (stat.lit_emit) begin
            if (tok_end) begin
              flag_bits   <= {flag_bits[6:0], 1'b0};
              if (flags_left != '0) flags_left <= flags_left - 1'b1;
              token_phase <= (flags_left <= 4'd1) ? PH_FLAG : PH_MID;
            end else begin
              token_phase <= is_cont ? token_phase + 3'd1 : 3'd5;
            end
          end else if (stat.match_go) begin
            flag_bits   <= {flag_bits[6:0], 1'b0};
            if (flags_left != '0) flags_left <= flags_left - 1'b1;
            token_phase <= (flags_left <= 4'd1) ? PH_FLAG : PH_MID;
          end
        end
      end
    end
  end

endmodule

// ===== rtl/core/lzss_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzss_ctrl
// Sequencer: input handshake, match copy loop and output register.
// ----------------------------------------------------------------------------
module lzss_ctrl
  import lzss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       in_last,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_byte,
  output logic       m_byte_valid,
  output logic       m_last,
  output logic [2:0] m_status,
  output lzss_cmd_t  cmd,
  input  lzss_stat_t stat,
  input  logic [7:0] emit_byte,
  input  logic [2:0] final_status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_COPY = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t     state, state_next;
  logic [6:0] left;
  logic [6:0] issued;
  logic       pend_last;
  logic [2:0] pend_status;
  logic       rd_valid;
  logic       out_free;
  logic       acc;
  logic       copy_go;
  logic       out_load;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign acc      = s_tvalid && s_tready;
  assign copy_go  = (state == S_COPY) && out_free;

  assign cmd.take      = acc;
  assign cmd.copy_rd   = copy_go && (issued != '0);
  assign cmd.copy_emit = copy_go && rd_valid;
  assign cmd.finish    = (acc && in_last && !stat.match_go) ||
                         (cmd.copy_emit && left == 7'd1 && pend_last);

  assign out_load = (acc && !stat.match_go && (stat.lit_emit || in_last)) || cmd.copy_emit;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (acc && stat.match_go) state_next = S_COPY;
      S_COPY:  if (cmd.copy_emit && left == 7'd1) state_next = S_IDLE;
      S_HOLD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      left     <= '0;
      issued   <= '0;
      rd_valid <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (acc) begin
        if (stat.match_go) begin
          left        <= stat.match_len;
          issued      <= stat.match_len;
          pend_last   <= in_last;
          pend_status <= final_status;
          rd_valid    <= 1'b0;
        end else if (stat.lit_emit || in_last) begin
          m_byte       <= stat.lit_emit ? emit_byte : 8'd0;
          m_byte_valid <= stat.lit_emit;
          m_last       <= 1'b1;
          m_status     <= in_last ? final_status : ST_RUN;
        end
      end
      if (copy_go) begin
        rd_valid <= (issued != '0);
        if (issued != '0) issued <= issued - 1'b1;
        if (cmd.copy_emit) begin
          left         <= left - 1'b1;
          m_byte       <= emit_byte;
          m_byte_valid <= 1'b1;
          m_last       <= (left == 7'd1);
          m_status     <= (left == 7'd1 && pend_last) ? pend_status : ST_RUN;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lzss_stream_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_unit
// LZSS stream decompressor with stored mode and 1/2/4-byte elements.
// ----------------------------------------------------------------------------
// One compressed byte per transfer on the slave side; decompressed bytes on
// the master side. Header and literal bytes are handled as they are accepted.
// A match is decoded on its second byte, then copied out of the window byte by
// byte through the single registered read port of the history RAM; no input is
// taken until the copy ends. The status is reported on the last transfer
// caused by the byte with tlast. The window RAM needs no clearing pass.
module lzss_stream_decompressor_unit
  import lzss_pkg::*;
#(
  parameter int WINDOW_BYTES = 16384,
  parameter int LENGTH_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_wdata,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // in_byte
  input  logic                   s_tlast,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,   // out_byte
  output logic                   m_tlast,
  output logic [3:0]             m_tuser    // status[2:0], byte_valid
);

  logic [LENGTH_BITS-1:0] out_length;
  lzss_cmd_t  cmd;
  lzss_stat_t stat;
  logic [7:0] emit_byte;
  logic [2:0] final_status;
  logic       bv;
  logic [2:0] st;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_length <= '0;
    end else if (cfg_we) begin
      out_length <= cfg_wdata;
    end
  end

  lzss_datapath #(.WINDOW_BYTES(WINDOW_BYTES), .LENGTH_BITS(LENGTH_BITS)) u_dp (
    .clk(clk), .rst(rst), .out_length(out_length), .in_byte(s_tdata),
    .in_last(s_tlast), .cmd(cmd), .stat(stat), .emit_byte(emit_byte),
    .final_status(final_status)
  );

  lzss_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .in_last(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_byte(m_tdata), .m_byte_valid(bv), .m_last(m_tlast), .m_status(st),
    .cmd(cmd), .stat(stat), .emit_byte(emit_byte), .final_status(final_status)
  );

  assign m_tuser = {st, bv};

endmodule

// ===== tb/lzss_stream_decompressor_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_unit_test
// Drives whole compressed streams (stored and LZSS modes, good and broken)
// into the decompressor and checks every output byte, tlast and status
// against a behavioral model kept in the scoreboard.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_unit_test
  import lzss_pkg::*;
();

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    logic       last;
    logic [2:0] status;
  } out_item_t;

  class lzss_scoreboard;
    logic [7:0]  hist [16384];
    int unsigned wpos, hcount, mode, flags, nflags, phase, hibyte, written;
    longint unsigned space, olen;
    logic [2:0]  err;
    out_item_t   pending[$];
    int          errors;

    function void clear_stream();
      wpos = 0; hcount = 0; mode = 0; flags = 0; nflags = 0; phase = PH_FLAG;
      hibyte = 0; written = 0; space = 0; err = ST_RUN;
    endfunction

    function void set_length(longint unsigned v);
      olen = v & 24'hFFFFFF;
    endfunction

    function void push(logic [7:0] b);
      out_item_t r;
      r = '{data: b, vld: 1'b1, last: 1'b0, status: ST_RUN};
      pending.push_back(r);
    endfunction

    function void emit(logic [7:0] b);
      hist[wpos] = b;
      wpos = (wpos + 1) % 16384;
      if (written < 16383) written++;
      if (space > 0) space--;
      push(b);
    endfunction

    function void token_end();
      flags = (flags << 1) & 8'hFF;
      if (nflags > 0) nflags--;
      phase = (nflags == 0) ? PH_FLAG : PH_MID;
    endfunction

    function void note_input(logic [7:0] b, logic last);
      int unsigned n0, elem, minm, info, off, len, rd;
      logic [2:0] st;
      out_item_t r;
      n0 = pending.size();
      elem = (mode == 1) ? 1 : (mode == 2) ? 2 : 4;
      minm = (mode == 1) ? 3 : (mode == 2) ? 2 : 1;
      if (hcount < 4) begin
        if (hcount == 0) begin
          space = olen;
          mode = b & 3;
          if (b > 3) err = ST_TYPE;
        end
        hcount++;
      end else if (err == ST_RUN) begin
        if (mode == MODE_STORED) begin
          if (space == 0) err = ST_OVER;
          else begin
            push(b);
            space--;
          end
        end else if (phase == PH_FLAG) begin
          flags = b; nflags = 8; phase = PH_FRESH;
        end else if (phase == PH_FRESH || phase == PH_MID) begin
          if (flags & FLAG_MSB) begin
            hibyte = b; phase = PH_LOW;
          end else if (space < elem) err = ST_OVER;
          else begin
            emit(b);
            if (elem == 1) token_end();
            else phase = PH_LIT0 + 1;
          end
        end else if (phase == PH_LOW) begin
          info = (hibyte << 8) | b;
          off = (info & OFFSET_MASK) * elem;
          len = ((info >> OFFSET_BITS) + minm) * elem;
          if (off == 0 || off > written || len > space) err = ST_OVER;
          else begin
            for (int i = 0; i < len; i++) begin
              rd = (wpos + 16384 - off) % 16384;
              emit(hist[rd]);
            end
            token_end();
          end
        end else begin
          emit(b);
          if (phase - PH_LIT0 + 1 >= elem) token_end();
          else phase++;
        end
      end
      if (last) begin
        if (hcount < 4) st = ST_OVER;
        else if (err != ST_RUN) st = err;
        else if (mode == MODE_STORED) st = (space > 0) ? ST_SIZE : ST_OK;
        else st = (phase == PH_FLAG || phase == PH_MID) ? ST_OK : ST_OVER;
        if (pending.size() == n0) begin
          r = '{data: 8'd0, vld: 1'b0, last: 1'b0, status: ST_RUN};
          pending.push_back(r);
        end
        pending[$].last = 1'b1;
        pending[$].status = st;
        clear_stream();
      end else if (pending.size() > n0) pending[$].last = 1'b1;
    endfunction

    function void check_output(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.data !== want.data || got.vld !== want.vld || got.last !== want.last ||
          got.status !== want.status) begin
        $display({"%0t: mismatch expected data=%h vld=%b last=%b st=%0d",
                  " actual data=%h vld=%b last=%b st=%0d"},
                 $time, want.data, want.vld, want.last, want.status,
                 got.data, got.vld, got.last, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [23:0] cfg_wdata = 0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = 0;
  logic        s_tlast = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [3:0]  m_tuser;

  lzss_scoreboard sb;
  bit  idle_ok = 1;
  bit  hold_rx = 0;
  int  cycles = 0;
  logic [7:0] strm[$];

  lzss_stream_decompressor_unit uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("lzss_stream_decompressor_unit_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_output('{data: m_tdata, vld: m_tuser[0], last: m_tlast, status: m_tuser[3:1]});
  end

  initial begin : receiver
    int gap;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_rx = 0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        m_tready <= 0;
        repeat (gap) @(posedge clk);
      end else begin
        m_tready <= 1;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    if (idle_ok && $urandom_range(0, 6) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, last);
  endtask

  task automatic send_stream();
    logic [7:0] b;
    while (strm.size() > 0) begin
      b = strm.pop_front();
      send_byte(b, strm.size() == 0);
    end
    s_tvalid <= 0;
    @(posedge clk);
  endtask

  task automatic drain_and_config(logic [23:0] v);
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_length(v);
  endtask

  task automatic header(logic [7:0] m);
    strm = {m, 8'($urandom), 8'($urandom), 8'($urandom)};
  endtask

  // LZSS body of ntok tokens; mostly valid matches, with an occasional zero offset
  task automatic lz_body(int m, int ntok);
    int unsigned elem, made, flg, off, ln;
    elem = (m == 1) ? 1 : (m == 2) ? 2 : 4;
    made = 0;
    for (int t = 0; t < ntok; t++) begin
      if (t % 8 == 0) begin
        flg = (made == 0) ? $urandom & 8'h7F : $urandom;
        strm.push_back(8'(flg));
      end
      if (flg & (8'h80 >> (t % 8))) begin
        off = $urandom_range(1, made / elem > 0 ? made / elem : 1);
        if ($urandom_range(0, 15) == 0) off = 0;
        ln = $urandom_range(0, 15);
        if (m != 1) ln = ln & 3;
        strm.push_back({ln[3:0], off[11:8]});
        strm.push_back(off[7:0]);
        made += (ln + 1) * elem;
      end else begin
        for (int k = 0; k < elem; k++) strm.push_back(8'($urandom));
        made += elem;
      end
    end
  endtask

  initial begin : stimulus
    int m;
    sb = new();
    sb.clear_stream();
    sb.set_length(0);
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // stored mode: exact, short, overflow
    drain_and_config(24'd3);
    header(MODE_STORED); strm.push_back(8'h00); strm.push_back(8'hFF); strm.push_back(8'h5A);
    send_stream();
    header(MODE_STORED); strm.push_back(8'hA5); send_stream();
    header(MODE_STORED); repeat (5) strm.push_back(8'($urandom)); send_stream();
    // invalid type, short header, empty stored
    header(8'hFF); strm.push_back(8'h11); send_stream();
    strm = {8'h01, 8'h00}; send_stream();
    drain_and_config(24'd0);
    header(MODE_STORED); send_stream();
    header(MODE_ELEM1); strm.push_back(8'h00); strm.push_back(8'h42); send_stream();
    drain_and_config(24'hFFFFFF);
    // offset zero, offset past written, end after flag, end inside match
    header(MODE_ELEM1); strm = {strm, 8'h40, 8'h41, 8'h00, 8'h00}; send_stream();
    header(MODE_ELEM1); strm = {strm, 8'h40, 8'h41, 8'h00, 8'h02}; send_stream();
    header(MODE_ELEM2); strm.push_back(8'h00); send_stream();
    header(MODE_ELEM1); strm = {strm, 8'h40, 8'h41, 8'hF0}; send_stream();
    // max-length match in 4-byte mode, pressure on output
    header(8'd3); strm = {strm, 8'h40, 8'h01, 8'h02, 8'h03, 8'h04, 8'hF0, 8'h01};
    hold_rx = 1;
    send_stream();
    header(8'd3); strm = {strm, 8'h00, 8'h01, 8'h02}; send_stream();

    // random streams across two length settings
    for (int s = 0; s < 4; s++) begin
      if (s % 2 == 0) drain_and_config(s == 2 ? 24'd20 : 24'($urandom_range(40, 400)));
      if (s == 3) idle_ok = 0;
      m = $urandom_range(0, 7);
      if (m == 0) begin
        header(MODE_STORED);
        repeat ($urandom_range(0, 8)) strm.push_back(8'($urandom));
      end else if (m == 7) begin
        header(8'($urandom));
        repeat ($urandom_range(0, 6)) strm.push_back(8'($urandom));
      end else begin
        m = (m % 3) + 1;
        header(8'(m));
        lz_body(m, $urandom_range(1, 6));
        if ($urandom_range(0, 7) == 0) void'(strm.pop_back());
      end
      if (s == 1) hold_rx = 1;
      send_stream();
    end

    while (sb.pending.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("lzss_stream_decompressor_unit_test: clean");
    end else begin
      $display("lzss_stream_decompressor_unit_test: errors");
    end
    $finish;
  end

endmodule
